[src/jacobi_gauss_seidel_solver_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear system solver
// Implication checks, sampled on the rising clock edge and masked by reset.
// ----------------------------------------------------------------------------
`ifndef JACOBI_GAUSS_SEIDEL_SOLVER_ASSERT_SVH
`define JACOBI_GAUSS_SEIDEL_SOLVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define JGS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jgs assertion failed");
// next-cycle implication
`define JGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jgs assertion failed");
`else
`define JGS_ASSERT_NOW(label, clk, rst, ante, cons)
`define JGS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/jgs_pkg.sv]
// ----------------------------------------------------------------------------
// jgs_pkg
// Field widths, codes and shared types of the linear system solver.
// ----------------------------------------------------------------------------
package jgs_pkg;

   localparam int ROW_W    = 4;
   localparam int COL_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SWEEP_W  = 16;
   localparam int TOL_W    = 17;
   localparam int CSR_IDX_W = 2;
   localparam int ACC_W    = 64;
   localparam int FRAC_W   = 16;

   // input word kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_START = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_CONVERGED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_LIMIT     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_ZERO_DIAG = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_UNKNOWNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_METHOD       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SWEEPS   = 2'd3;

   localparam logic METHOD_JACOBI = 1'b0;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[src/jacobi_gauss_seidel_solver.sv]
// ----------------------------------------------------------------------------
// jacobi_gauss_seidel_solver
// Jacobi / Gauss-Seidel solver for Ax=b in Q16.16 on a loaded augmented matrix.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// req_*     in         req_valid / req_stall  kind, row, col, coefficient
// rsp_*     out        rsp_valid / rsp_stall  unknown_index, solution, status,
//                                             sweeps_done, last
// csr_*     in         csr_valid / csr_ready  index, wdata
//
// A load word is written into the store as it is accepted. A start word first checks
// every diagonal entry, then runs sweeps: one shared 32x32 multiplier step per
// off-diagonal coefficient and a serial divide per row, over one store read
// port. Results follow, one per cycle unless rsp_stall holds them.
// req_stall stays high from the start word until the last result is issued.
// Reset is synchronous; the coefficient store is not cleared.
// ----------------------------------------------------------------------------
`include "jacobi_gauss_seidel_solver_assert.svh"

module jacobi_gauss_seidel_solver #(
   parameter int MAX_UNKNOWNS = 16,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic [jgs_pkg::ROW_W-1:0]             req_row,
   input  logic [jgs_pkg::COL_W-1:0]             req_col,
   input  logic signed [jgs_pkg::DATA_W-1:0]     req_coefficient,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [jgs_pkg::ROW_W-1:0]             rsp_unknown_index,
   output logic signed [jgs_pkg::DATA_W-1:0]     rsp_solution,
   output logic [jgs_pkg::STATUS_W-1:0]          rsp_status,
   output logic [jgs_pkg::SWEEP_W-1:0]           rsp_sweeps_done,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [jgs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [jgs_pkg::DATA_W-1:0]            csr_wdata
);
   import jgs_pkg::*;

   localparam int STORE_COLS = MAX_UNKNOWNS + 1;
   localparam int DEPTH      = MAX_UNKNOWNS * STORE_COLS;
   localparam int AW         = $clog2(DEPTH);
   localparam int IW         = $clog2(MAX_UNKNOWNS);
   localparam int NW         = $clog2(MAX_UNKNOWNS + 1);
   localparam logic signed [ACC_W:0] ACC_MAX = {2'b00, {(ACC_W - 1){1'b1}}};

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIAG_RD, ST_DIAG_CHK, ST_SW_START, ST_ROW_B, ST_ROW_B2,
      ST_EL_RD, ST_EL_MUL, ST_EL_ACC, ST_DIV_GO, ST_DIV_WAIT, ST_SW_END, ST_EMIT
   } state_type;

   state_type state_ff;

   // configuration
   logic [COL_W-1:0]   cfg_n_ff;
   logic               cfg_method_ff;
   logic [TOL_W-1:0]   cfg_tol_ff;
   logic [SWEEP_W-1:0] cfg_max_ff;

   // sequencer
   logic [NW-1:0]      n_ff;
   logic [SWEEP_W-1:0] limit_ff, sweep_ff;
   logic [IW-1:0]      i_ff, j_ff, k_ff;
   logic               sel_ff, all_ok_ff, zero_ff;
   logic [STATUS_W-1:0] status_ff;
   logic signed [ACC_W-1:0]  acc_ff, prod_ff;
   logic signed [DATA_W-1:0] diag_ff, old_ff, xj_ff;

   // coefficient store
   logic signed [DATA_W-1:0] store_mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic                     wr_en;
   logic [NW-1:0]            rd_col;

   // solution banks: one holds the previous sweep, the other the current one
   logic signed [DATA_W-1:0] bank0_ff [MAX_UNKNOWNS];
   logic signed [DATA_W-1:0] bank1_ff [MAX_UNKNOWNS];
   logic [MAX_UNKNOWNS-1:0]  v0_ff, v1_ff;
   logic [IW-1:0]            vidx;
   logic                     rbank;
   logic signed [DATA_W-1:0] vec_rd;

   // result register
   logic                     rsp_valid_ff, rsp_last_ff;
   logic [ROW_W-1:0]         rsp_idx_ff;
   logic signed [DATA_W-1:0] rsp_sol_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [SWEEP_W-1:0]       rsp_sweeps_ff;

   // divider
   div_stat_type             div_stat;
   logic signed [DATA_W-1:0] div_q;

   logic                     req_acc;
   logic [NW-1:0]            n_clamp;
   logic [IW-1:0]            last_idx;
   logic signed [ACC_W:0]    acc_diff;
   logic signed [ACC_W-1:0]  acc_sat;
   logic signed [DATA_W:0]   conv_diff;
   logic [DATA_W:0]          conv_mag;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign last_idx  = IW'(n_ff - 1'b1);

   always_comb begin
      if (32'(cfg_n_ff) < 32'd2) begin
         n_clamp = NW'(2);
      end else if (32'(cfg_n_ff) > 32'(MAX_UNKNOWNS)) begin
         n_clamp = NW'(MAX_UNKNOWNS);
      end else begin
         n_clamp = NW'(cfg_n_ff);
      end
   end

   // store ports
   always_comb begin
      wr_en   = req_acc && (req_kind == KIND_LOAD)
                && (32'(req_row) < 32'(MAX_UNKNOWNS))
                && (32'(req_col) <= 32'(MAX_UNKNOWNS));
      wr_addr = AW'(32'(req_row) * STORE_COLS + 32'(req_col));
      case (state_ff)
         ST_DIAG_RD: rd_col = NW'(i_ff);
         ST_ROW_B:   rd_col = n_ff;
         default:    rd_col = NW'(j_ff);
      endcase
      rd_addr = AW'(32'(i_ff) * STORE_COLS + 32'(rd_col));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= req_coefficient;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // vector read: results, or x_j from the bank the update rule selects
   always_comb begin
      if (state_ff == ST_EMIT) begin
         vidx  = k_ff;
         rbank = sel_ff;
      end else begin
         vidx  = j_ff;
         rbank = (cfg_method_ff != METHOD_JACOBI && j_ff < i_ff) ? ~sel_ff : sel_ff;
      end
      if (rbank) begin
         vec_rd = v1_ff[vidx] ? bank1_ff[vidx] : '0;
      end else begin
         vec_rd = v0_ff[vidx] ? bank0_ff[vidx] : '0;
      end
   end

   // saturating accumulate and convergence distance
   always_comb begin
      acc_diff = {acc_ff[ACC_W-1], acc_ff} - {prod_ff[ACC_W-1], prod_ff};
      if (acc_diff > ACC_MAX) begin
         acc_sat = ACC_W'(ACC_MAX);
      end else if (acc_diff < -ACC_MAX) begin
         acc_sat = ACC_W'(-ACC_MAX);
      end else begin
         acc_sat = ACC_W'(acc_diff);
      end
      conv_diff = {div_q[DATA_W-1], div_q} - {old_ff[DATA_W-1], old_ff};
      conv_mag  = conv_diff[DATA_W] ? (DATA_W + 1)'(-conv_diff) : (DATA_W + 1)'(conv_diff);
   end

   jgs_div #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_DIV_GO),
      .dividend (acc_ff),
      .divisor  (diag_ff),
      .quotient (div_q),
      .stat     (div_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cfg_n_ff      <= COL_W'(2);
         cfg_method_ff <= METHOD_JACOBI;
         cfg_tol_ff    <= TOL_W'(655);
         cfg_max_ff    <= SWEEP_W'(1000);
         v0_ff         <= '0;
         v1_ff         <= '0;
         sel_ff        <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_UNKNOWNS: cfg_n_ff      <= csr_wdata[COL_W-1:0];
               CSR_METHOD:       cfg_method_ff <= csr_wdata[0];
               CSR_TOLERANCE:    cfg_tol_ff    <= csr_wdata[TOL_W-1:0];
               CSR_MAX_SWEEPS:   cfg_max_ff    <= csr_wdata[SWEEP_W-1:0];
               default: ;
            endcase
         end

         // the emit state refills the result register on its own
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_kind == KIND_START) begin
                  n_ff     <= n_clamp;
                  limit_ff <= (cfg_max_ff == '0) ? SWEEP_W'(1) : cfg_max_ff;
                  sweep_ff <= '0;
                  v0_ff    <= '0;
                  v1_ff    <= '0;
                  sel_ff   <= 1'b0;
                  zero_ff  <= 1'b0;
                  i_ff     <= '0;
                  state_ff <= ST_DIAG_RD;
               end
            end
            ST_DIAG_RD: state_ff <= ST_DIAG_CHK;
            ST_DIAG_CHK: begin
               if (rd_data_ff == '0) begin
                  zero_ff <= 1'b1;
               end
               if (i_ff == last_idx) begin
                  if (zero_ff || rd_data_ff == '0) begin
                     status_ff <= STAT_ZERO_DIAG;
                     k_ff      <= '0;
                     state_ff  <= ST_EMIT;
                  end else begin
                     state_ff <= ST_SW_START;
                  end
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_DIAG_RD;
               end
            end
            ST_SW_START: begin
               i_ff      <= '0;
               all_ok_ff <= 1'b1;
               sweep_ff  <= sweep_ff + 1'b1;
               state_ff  <= ST_ROW_B;
            end
            ST_ROW_B: begin
               j_ff     <= '0;
               state_ff <= ST_ROW_B2;
            end
            ST_ROW_B2: begin
               acc_ff   <= ACC_W'(rd_data_ff) <<< FRAC_W;
               state_ff <= ST_EL_RD;
            end
            ST_EL_RD: begin
               xj_ff    <= vec_rd;
               state_ff <= ST_EL_MUL;
            end
            ST_EL_MUL: begin
               if (j_ff == i_ff) begin
                  // diagonal slot: keep a_ii and the old x_i, skip the product
                  diag_ff <= rd_data_ff;
                  old_ff  <= xj_ff;
                  if (j_ff == last_idx) begin
                     state_ff <= ST_DIV_GO;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_EL_RD;
                  end
               end else begin
                  prod_ff  <= ACC_W'(rd_data_ff) * ACC_W'(xj_ff);
                  state_ff <= ST_EL_ACC;
               end
            end
            ST_EL_ACC: begin
               acc_ff <= acc_sat;
               if (j_ff == last_idx) begin
                  state_ff <= ST_DIV_GO;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_EL_RD;
               end
            end
            ST_DIV_GO: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_stat.done) begin
                  if (sel_ff) begin
                     bank0_ff[i_ff] <= div_q;
                     v0_ff[i_ff]    <= 1'b1;
                  end else begin
                     bank1_ff[i_ff] <= div_q;
                     v1_ff[i_ff]    <= 1'b1;
                  end
                  if (conv_mag > (DATA_W + 1)'(cfg_tol_ff)) begin
                     all_ok_ff <= 1'b0;
                  end
                  if (i_ff == last_idx) begin
                     state_ff <= ST_SW_END;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= ST_ROW_B;
                  end
               end
            end
            ST_SW_END: begin
               // the bank just written becomes the previous vector
               sel_ff <= ~sel_ff;
               k_ff   <= '0;
               if (all_ok_ff) begin
                  status_ff <= STAT_CONVERGED;
                  state_ff  <= ST_EMIT;
               end else if (sweep_ff >= limit_ff) begin
                  status_ff <= STAT_LIMIT;
                  state_ff  <= ST_EMIT;
               end else begin
                  state_ff <= ST_SW_START;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_idx_ff    <= ROW_W'(k_ff);
                  rsp_sol_ff    <= zero_ff ? '0 : vec_rd;
                  rsp_status_ff <= status_ff;
                  rsp_sweeps_ff <= sweep_ff;
                  rsp_last_ff   <= (k_ff == last_idx);
                  if (k_ff == last_idx) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_unknown_index = rsp_idx_ff;
   assign rsp_solution      = rsp_sol_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_sweeps_done   = rsp_sweeps_ff;
   assign rsp_last          = rsp_last_ff;

   `JGS_ASSERT_NOW(a_last_index, clock, reset, rsp_valid && rsp_last,
      rsp_unknown_index == ROW_W'(n_ff - 1'b1))
   `JGS_ASSERT_NOW(a_zero_diag_result, clock, reset,
      rsp_valid && rsp_status == STAT_ZERO_DIAG,
      rsp_solution == '0 && rsp_sweeps_done == '0)
   `JGS_ASSERT_NOW(a_swept, clock, reset,
      rsp_valid && (rsp_status == STAT_CONVERGED || rsp_status == STAT_LIMIT),
      rsp_sweeps_done != '0)
   `JGS_ASSERT_NEXT(a_run_ends, clock, reset, rsp_valid && !rsp_stall && rsp_last,
      !rsp_valid)
   `JGS_ASSERT_NOW(a_div_idle, clock, reset, state_ff == ST_DIV_GO, !div_stat.busy)

endmodule

[src/jgs_div.sv]
// ----------------------------------------------------------------------------
// jgs_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero,
// result saturated to the configured value width.
// ----------------------------------------------------------------------------
module jgs_div #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [jgs_pkg::ACC_W-1:0]    dividend,
   input  logic signed [jgs_pkg::DATA_W-1:0]   divisor,
   output logic signed [jgs_pkg::DATA_W-1:0]   quotient,
   output jgs_pkg::div_stat_type               stat
);
   import jgs_pkg::*;

   localparam int SAT_W = (VALUE_WIDTH > DATA_W) ? DATA_W : VALUE_WIDTH;
   localparam logic [ACC_W-1:0] HI_MAG = ACC_W'((64'd1 << (SAT_W - 1)) - 64'd1);
   localparam int CNT_W = $clog2(ACC_W);

   logic                 run_ff, fin_ff, done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [ACC_W-1:0]     num_ff, quo_ff;
   logic [DATA_W-1:0]    rem_ff, dvs_ff;
   logic                 neg_ff;
   logic signed [DATA_W-1:0] quotient_ff;

   logic [DATA_W:0]      trial;
   logic                 qbit;
   logic [ACC_W-1:0]     quo_in;

   always_comb begin
      trial  = {rem_ff, num_ff[ACC_W-1]};
      qbit   = (trial >= {1'b0, dvs_ff});
      quo_in = {quo_ff[ACC_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         // pulse done for one cycle once the last step has been clamped
         done_ff <= !start && !run_ff && fin_ff;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            quo_ff <= '0;
            num_ff <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
            dvs_ff <= divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
            neg_ff <= dividend[ACC_W-1] ^ divisor[DATA_W-1];
         end else if (run_ff) begin
            rem_ff <= qbit ? DATA_W'(trial - {1'b0, dvs_ff}) : DATA_W'(trial);
            quo_ff <= quo_in;
            num_ff <= {num_ff[ACC_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ACC_W - 1)) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end else if (fin_ff) begin
            // clamp magnitude, then apply sign
            fin_ff  <= 1'b0;
            if (!neg_ff) begin
               quotient_ff <= (quo_ff > HI_MAG) ? DATA_W'(HI_MAG) : DATA_W'(quo_ff);
            end else if (quo_ff > HI_MAG + 1'b1) begin
               quotient_ff <= DATA_W'(-(HI_MAG + 1'b1));
            end else begin
               quotient_ff <= DATA_W'(-quo_ff);
            end
         end
      end
   end

   assign quotient  = quotient_ff;
   assign stat.busy = run_ff | fin_ff;
   assign stat.done = done_ff;

endmodule

[tb/jacobi_gauss_seidel_solver_tb.sv]
// ----------------------------------------------------------------------------
// jacobi_gauss_seidel_solver_tb
// Loads augmented matrices word by word, starts Jacobi and Gauss-Seidel
// solves under several register settings and checks every solution word
// against a fixed-point solver model kept in this bench.
// ----------------------------------------------------------------------------
module jacobi_gauss_seidel_solver_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jgs_pkg::*;

   localparam int MAXN = 16;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int RUN_BUDGET = 8;
   localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [ROW_W-1:0]          idx;
      logic signed [DATA_W-1:0]  sol;
      logic [STATUS_W-1:0]       status;
      logic [SWEEP_W-1:0]        sweeps;
      logic                      last;
   } soln_word_type;

   typedef struct {
      logic              kind;
      int                row;
      int                col;
      logic [DATA_W-1:0] coef;
      bit                zero_diag;
   } vec_row_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_kind;
   logic [ROW_W-1:0]           req_row;
   logic [COL_W-1:0]           req_col;
   logic signed [DATA_W-1:0]   req_coefficient;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [ROW_W-1:0]           rsp_unknown_index;
   logic signed [DATA_W-1:0]   rsp_solution;
   logic [STATUS_W-1:0]        rsp_status;
   logic [SWEEP_W-1:0]         rsp_sweeps_done;
   logic                       rsp_last;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [DATA_W-1:0]          csr_wdata;

   jacobi_gauss_seidel_solver uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_row(req_row), .req_col(req_col), .req_coefficient(req_coefficient),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_unknown_index(rsp_unknown_index), .rsp_solution(rsp_solution),
      .rsp_status(rsp_status), .rsp_sweeps_done(rsp_sweeps_done),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // model state
   logic signed [DATA_W-1:0] coef_store [MAXN][MAXN+1];
   bit                       written [MAXN][MAXN+1];
   logic [COL_W-1:0]         cfg_unknowns;
   logic                     cfg_method;
   logic [TOL_W-1:0]         cfg_tolerance;
   logic [SWEEP_W-1:0]       cfg_max_sweeps;

   soln_word_type solution_q[$];
   int  errors = 0;
   int  cycles = 0;
   bit  quiet = 0;
   bit  long_hold_req = 0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic longint acc_add(longint a, longint b);
      if (b > 0 && a > ACC_MAX - b) return ACC_MAX;
      if (b < 0 && a < -ACC_MAX - b) return -ACC_MAX;
      return a + b;
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp_value(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[DATA_W-1:0];
   endfunction

   function automatic int rnd_signed(int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   // run the iteration and queue one solution word per unknown
   task automatic solve_system();
      int n, lim, sweeps;
      bit zd, ok;
      longint acc, d;
      logic signed [DATA_W-1:0] cur [MAXN];
      logic signed [DATA_W-1:0] prev [MAXN];
      logic signed [DATA_W-1:0] xj;
      logic [STATUS_W-1:0] st;
      soln_word_type w;
      n = cfg_unknowns < 2 ? 2 : (cfg_unknowns > MAXN ? MAXN : int'(cfg_unknowns));
      lim = cfg_max_sweeps == 0 ? 1 : int'(cfg_max_sweeps);
      sweeps = 0;
      zd = 0;
      for (int i = 0; i < MAXN; i++) cur[i] = '0;
      for (int i = 0; i < n; i++) if (coef_store[i][i] == 0) zd = 1;
      if (zd) begin
         st = STAT_ZERO_DIAG;
      end else begin
         forever begin
            prev = cur;
            sweeps++;
            for (int i = 0; i < n; i++) begin
               acc = longint'(coef_store[i][n]) * 65536;
               for (int j = 0; j < n; j++) begin
                  if (j == i) continue;
                  xj = cfg_method ? cur[j] : prev[j];
                  acc = acc_add(acc, -(longint'(coef_store[i][j]) * longint'(xj)));
               end
               cur[i] = clamp_value(acc / longint'(coef_store[i][i]));
            end
            ok = 1;
            for (int i = 0; i < n; i++) begin
               d = longint'(cur[i]) - longint'(prev[i]);
               if (d < 0) d = -d;
               if (d > longint'(cfg_tolerance)) ok = 0;
            end
            if (ok) begin
               st = STAT_CONVERGED;
               break;
            end
            if (sweeps >= lim) begin
               st = STAT_LIMIT;
               break;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         w.idx = ROW_W'(i);
         w.sol = zd ? '0 : cur[i];
         w.status = st;
         w.sweeps = SWEEP_W'(sweeps);
         w.last = (i == n - 1);
         solution_q.push_back(w);
      end
   endtask

   task automatic send_word(logic kind, int row, int col, logic [DATA_W-1:0] coef);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_row = ROW_W'(row);
      req_col = COL_W'(col);
      req_coefficient = coef;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == KIND_LOAD) begin
         if (col <= MAXN) begin
            coef_store[row][col] = coef;
            written[row][col] = 1;
         end
      end else begin
         solve_system();
      end
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      req_valid = 1'b0;
      while (solution_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_NUM_UNKNOWNS: cfg_unknowns = data[COL_W-1:0];
         CSR_METHOD:       cfg_method = data[0];
         CSR_TOLERANCE:    cfg_tolerance = data[TOL_W-1:0];
         CSR_MAX_SWEEPS:   cfg_max_sweeps = data[SWEEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // load an augmented matrix for n unknowns, then start; returns the in-range words sent
   task automatic run_system(int n, bit diag_only, bit hold, output int sent);
      logic [DATA_W-1:0] v;
      int z;
      sent = 0;
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c <= n; c++) begin
            if (!diag_only && written[r][c] && $urandom_range(0, 2) == 0) continue;
            if (diag_only)
               v = (c == r) ? ($urandom_range(0, 1) ? 32'h1 : -32'sh1) * 65536
                              * $urandom_range(1, 8)
                            : (c == n ? $urandom : '0);
            else if ($urandom_range(0, 7) == 0)
               v = $urandom;
            else if (c == r)
               v = ($urandom_range(0, 1) ? 1 : -1)
                   * (n * 131072 + int'($urandom_range(0, 262144)));
            else if (c == n)
               v = rnd_signed(1 << 20);
            else
               v = rnd_signed(1 << 16);
            send_word(KIND_LOAD, r, c, v);
            sent++;
            if (!diag_only && $urandom_range(0, 9) == 0)
               send_word(KIND_LOAD, $urandom_range(0, 15), $urandom_range(17, 31), $urandom);
         end
      end
      if (!diag_only && $urandom_range(0, 9) == 0) begin
         z = $urandom_range(0, n - 1);
         send_word(KIND_LOAD, z, z, '0);
         sent++;
      end
      if (hold) long_hold_req = 1;
      send_word(KIND_START, $urandom_range(0, 15), $urandom_range(0, 31), $urandom);
      sent++;
   endtask

   // result side: random stall bursts, one long hold on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 0;
            rsp_stall = 1'b1;
            repeat (6000) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      soln_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (solution_q.size() == 0) begin
            $error("solution word with nothing expected: index %0d", rsp_unknown_index);
            errors++;
         end else begin
            e = solution_q.pop_front();
            if (rsp_unknown_index !== e.idx) begin
               $error("unknown_index exp %0d got %0d", e.idx, rsp_unknown_index);
               errors++;
            end
            if (rsp_solution !== e.sol) begin
               $error("solution exp %0d got %0d", e.sol, rsp_solution);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_sweeps_done !== e.sweeps) begin
               $error("sweeps_done exp %0d got %0d", e.sweeps, rsp_sweeps_done);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   vec_row_type vectors [] = '{
      '{KIND_LOAD,  0,  0, 32'h0000_0000, 0},
      '{KIND_LOAD,  0,  1, 32'h0001_0000, 0},
      '{KIND_LOAD,  0,  2, 32'h0003_0000, 0},
      '{KIND_LOAD,  1,  0, 32'h0001_0000, 0},
      '{KIND_LOAD,  1,  1, 32'h0002_0000, 0},
      '{KIND_LOAD,  1,  2, 32'hFFFF_0000, 0},
      '{KIND_START, 0,  0, 32'h0000_0000, 1},
      '{KIND_LOAD,  0,  0, 32'h7FFF_FFFF, 0},
      '{KIND_START, 0,  0, 32'h0000_0000, 0},
      '{KIND_LOAD,  1,  1, 32'h8000_0000, 0},
      '{KIND_LOAD,  0,  1, 32'h8000_0000, 0},
      '{KIND_LOAD,  1,  0, 32'h7FFF_FFFF, 0},
      '{KIND_LOAD,  0,  2, 32'h7FFF_FFFF, 0},
      '{KIND_LOAD,  1,  2, 32'h8000_0000, 0},
      '{KIND_START, 15, 31, 32'hFFFF_FFFF, 0},
      '{KIND_LOAD,  15, 31, 32'hFFFF_FFFF, 0},
      '{KIND_LOAD,  15, 16, 32'hFFFF_FFFF, 0},
      '{KIND_LOAD,  1,  1, 32'hFFFF_FFFF, 0},
      '{KIND_START, 0,  0, 32'h0000_0000, 0},
      '{KIND_LOAD,  0,  0, 32'h0000_0001, 0},
      '{KIND_LOAD,  1,  1, 32'h0001_0000, 0},
      '{KIND_LOAD,  0,  1, 32'h0000_0000, 0},
      '{KIND_LOAD,  1,  0, 32'h0000_0000, 0},
      '{KIND_START, 0,  0, 32'h0000_0000, 0}
   };

   int ph_unknowns [8] = '{0, 3, 2, 4, 31, 5, 3, 2};
   int ph_tol [8]      = '{655, 0, 131071, 65536, 0, 1000, 655, 20000};

   initial begin
      int sent, budget;
      soln_word_type w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_LOAD;
      req_row = '0;
      req_col = '0;
      req_coefficient = '0;
      csr_valid = 1'b0;
      csr_index = CSR_NUM_UNKNOWNS;
      csr_wdata = '0;
      cfg_unknowns = 2;
      cfg_method = METHOD_JACOBI;
      cfg_tolerance = 655;
      cfg_max_sweeps = 1000;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // one sweep per solve keeps extreme values quick
      csr_write(CSR_NUM_UNKNOWNS, 32'd1);
      csr_write(CSR_MAX_SWEEPS, 32'd0);
      foreach (vectors[k]) begin
         if (vectors[k].zero_diag) begin
            // zero diagonal: all-zero solution, no sweep done
            req_valid = 1'b1;
            req_kind = vectors[k].kind;
            req_row = ROW_W'(vectors[k].row);
            req_col = COL_W'(vectors[k].col);
            req_coefficient = vectors[k].coef;
            @(posedge clock);
            while (req_stall) @(posedge clock);
            for (int i = 0; i < 2; i++) begin
               w.idx = ROW_W'(i);
               w.sol = '0;
               w.status = STAT_ZERO_DIAG;
               w.sweeps = '0;
               w.last = (i == 1);
               solution_q.push_back(w);
            end
            @(negedge clock);
         end else begin
            send_word(vectors[k].kind, vectors[k].row, vectors[k].col, vectors[k].coef);
         end
      end

      for (int p = 0; p < 8; p++) begin
         csr_write(CSR_NUM_UNKNOWNS, ph_unknowns[p]);
         csr_write(CSR_METHOD, 32'(p[0]));
         csr_write(CSR_TOLERANCE, ph_tol[p]);
         csr_write(CSR_MAX_SWEEPS, ph_unknowns[p] == 31 ? 32'd65535 : $urandom_range(1, 30));
         if (p == 7) quiet = 1;
         if (ph_unknowns[p] == 31) begin
            run_system(MAXN, 1, 0, sent);
         end else begin
            budget = RUN_BUDGET;
            while (budget > 0) begin
               run_system(ph_unknowns[p] < 2 ? 2 : ph_unknowns[p], 0,
                          p == 2 && budget == RUN_BUDGET, sent);
               budget -= sent;
            end
         end
      end

      req_valid = 1'b0;
      while (solution_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/jgs_pkg.sv
src/jgs_div.sv
src/jacobi_gauss_seidel_solver.sv
tb/jacobi_gauss_seidel_solver_tb.sv
